// File: sv/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: sv/kts_pkg.sv
// Package with the types, codes and constants of the keyed table.
package kts_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_MEMBER = 2'd3
  } kts_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE   = 2'd0,
    STS_ABSENT = 2'd1,
    STS_DUP    = 2'd2,
    STS_FULL   = 2'd3
  } kts_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_FINISH
  } kts_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic search;
    logic shift;
    logic finish;
  } kts_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic scan_done;
    logic is_delete;
    logic hit;
    logic out_free;
  } kts_dp_sts_t;

endpackage

// File: sv/kts_if.sv
// Valid/ready channel interfaces for the request and result transactions.
interface kts_in_if;
  logic                          valid;
  logic                          ready;
  logic [kts_pkg::CMD_W-1:0]     command;
  logic [kts_pkg::KEY_W-1:0]     key;
  logic [kts_pkg::VALUE_W-1:0]   value_in;

  modport source (output valid, command, key, value_in, input ready);
  modport sink   (input valid, command, key, value_in, output ready);
endinterface

interface kts_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [kts_pkg::VALUE_W-1:0]   value_out;
  logic [kts_pkg::COUNT_W-1:0]   entry_count;
  logic                          is_empty;
  logic                          is_full;
  logic [kts_pkg::STATUS_W-1:0]  status;

  modport source (output valid, found, value_out, entry_count, is_empty, is_full, status,
                  input ready);
  modport sink   (input valid, found, value_out, entry_count, is_empty, is_full, status,
                  output ready);
endinterface

// File: sv/keyed_table_linear_search.sv
// Top level of the keyed table with linear search.
//
// The block keeps up to DEPTH key/value pairs in insertion order in one RAM and serves one
// transaction at a time: insert (appended only when the key is absent and the table has
// room), delete (the match is removed and later entries move down one place), lookup and
// membership query. The table is scanned from the oldest entry, one entry per cycle, and the
// first equal key is the match. The scan reads the stored entries in order until the key is
// found or every entry has been read; a delete that finds its key then shifts the later
// entries down, and a new result waits while the previous one is still unread in the output
// register. The time a transaction takes is set by the single read port of the table RAM,
// which both the scan and the shift use, and by its registered read data. Each transaction
// yields exactly one result, held in an output register; a new request is taken once the
// previous one has been handed to that register, so the block keeps working while a result
// waits for the consumer. Only the low KEY_BITS bits of a key and the low VALUE_BITS bits of
// a value are stored and compared. entry_count carries the low five bits of the occupancy;
// value_out is zero unless a lookup finds its key.
`include "assert_macros.svh"

module keyed_table_linear_search #(
  parameter int DEPTH      = kts_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = kts_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kts_pkg::VALUE_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  kts_in_if.sink    in_chan,
  kts_out_if.source out_chan
);

  kts_pkg::kts_ctrl_t   ctrl;
  kts_pkg::kts_dp_sts_t sts;
  kts_pkg::kts_state_t  state;
  logic                 in_ready;

  assign in_chan.ready = in_ready;

  // Sequencer: idle, scan for the key, shift down after a delete, then post the result.
  kts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctrl     (ctrl),
    .state    (state)
  );

  // Table storage, scan pointer, occupancy and the result register.
  kts_datapath #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_chan.command),
    .in_key          (in_chan.key),
    .in_value_in     (in_chan.value_in),
    .ctrl            (ctrl),
    .sts             (sts),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_found       (out_chan.found),
    .out_value_out   (out_chan.value_out),
    .out_entry_count (out_chan.entry_count),
    .out_is_empty    (out_chan.is_empty),
    .out_is_full     (out_chan.is_full),
    .out_status      (out_chan.status)
  );

  // An accepted transaction always starts a scan on the next cycle.
  `ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, in_chan.valid && in_ready, state == kts_pkg::S_SEARCH)

  // Posting a result always leaves a valid result at the output.
  `ASSERT_NEXT(a_finish_posts_result, clk, rst_n, ctrl.finish, out_chan.valid)

  // The shift only runs for a delete whose key was found.
  `ASSERT_IMPLIES(a_shift_needs_hit, clk, rst_n, state == kts_pkg::S_SHIFT, sts.hit && sts.is_delete)

endmodule

// File: sv/kts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/kts_datapath.sv
// Datapath of the keyed table: table RAM, scan pointer, occupancy and result register.
module kts_datapath #(
  parameter int DEPTH      = kts_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = kts_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kts_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [kts_pkg::CMD_W-1:0]       in_command,
  input  logic [kts_pkg::KEY_W-1:0]       in_key,
  input  logic [kts_pkg::VALUE_W-1:0]     in_value_in,
  input  kts_pkg::kts_ctrl_t              ctrl,
  output kts_pkg::kts_dp_sts_t            sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [kts_pkg::VALUE_W-1:0]     out_value_out,
  output logic [kts_pkg::COUNT_W-1:0]     out_entry_count,
  output logic                            out_is_empty,
  output logic                            out_is_full,
  output logic [kts_pkg::STATUS_W-1:0]    out_status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = KEY_BITS + VALUE_BITS;

  kts_pkg::kts_cmd_t        cmd_r;
  logic [KEY_BITS-1:0]      key_r;
  logic [VALUE_BITS-1:0]    val_r;
  logic [VALUE_BITS-1:0]    vout_r;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            idx_r;
  logic [CW-1:0]            pend_idx_r;
  logic [CW-1:0]            shift_dst;
  logic                     pend_r;
  logic                     hit_r;
  logic                     out_valid_r;

  logic                     found_r;
  logic [kts_pkg::VALUE_W-1:0]  value_out_r, value_out_nxt;
  logic [kts_pkg::COUNT_W-1:0]  entry_count_r;
  logic                     is_empty_r, is_full_r;
  kts_pkg::kts_status_t     status_r, status_nxt;

  logic                     issue, match_now, ins_ok, del_ok;
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [WW-1:0]            ram_wdata, ram_rdata;
  logic [KEY_BITS-1:0]      rd_key;
  logic [VALUE_BITS-1:0]    rd_val;
  logic [KEY_BITS+kts_pkg::KEY_W-1:0]       key_ext;
  logic [VALUE_BITS+kts_pkg::VALUE_W-1:0]   vin_ext, vout_ext;
  logic [CW+kts_pkg::COUNT_W-1:0]           count_ext;

  kts_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key    = ram_rdata[WW-1:VALUE_BITS];
  assign rd_val    = ram_rdata[VALUE_BITS-1:0];
  assign issue     = idx_r < count_r;
  assign match_now = pend_r && (rd_key == key_r);
  assign shift_dst = pend_idx_r - 1'b1;

  assign key_ext   = {{KEY_BITS{1'b0}}, in_key};
  assign vin_ext   = {{VALUE_BITS{1'b0}}, in_value_in};
  assign vout_ext  = {{kts_pkg::VALUE_W{1'b0}}, vout_r};

  assign ins_ok = (cmd_r == kts_pkg::CMD_INSERT) && !hit_r && (count_r < CW'(DEPTH));
  assign del_ok = (cmd_r == kts_pkg::CMD_DELETE) && hit_r;

  // RAM ports: scan reads in both search and shift; writes for the shift and the insert.
  always_comb begin
    ram_re    = (ctrl.search || ctrl.shift) && issue;
    ram_raddr = idx_r[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = shift_dst[AW-1:0];
    ram_wdata = ram_rdata;
    if (ctrl.shift && pend_r) begin
      ram_we = 1'b1;
    end else if (ctrl.finish && ins_ok) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[AW-1:0];
      ram_wdata = {key_r, val_r};
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (del_ok) begin
      count_nxt = CW'(count_r - 1'b1);
    end
    status_nxt = hit_r ? kts_pkg::STS_DONE : kts_pkg::STS_ABSENT;
    if (cmd_r == kts_pkg::CMD_INSERT) begin
      if (hit_r) begin
        status_nxt = kts_pkg::STS_DUP;
      end else if (!ins_ok) begin
        status_nxt = kts_pkg::STS_FULL;
      end else begin
        status_nxt = kts_pkg::STS_DONE;
      end
    end
    value_out_nxt = '0;
    if ((cmd_r == kts_pkg::CMD_LOOKUP) && hit_r) begin
      value_out_nxt = vout_ext[kts_pkg::VALUE_W-1:0];
    end
  end

  assign count_ext = {{kts_pkg::COUNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.load) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
        hit_r  <= 1'b0;
      end else if (ctrl.search && match_now) begin
        hit_r  <= 1'b1;
        idx_r  <= CW'(pend_idx_r + 1'b1);
        pend_r <= 1'b0;
      end else if (ctrl.search || ctrl.shift) begin
        pend_r <= issue;
        if (issue) begin
          idx_r <= CW'(idx_r + 1'b1);
        end
      end
      if (ctrl.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= kts_pkg::kts_cmd_t'(in_command);
      key_r <= key_ext[KEY_BITS-1:0];
      val_r <= vin_ext[VALUE_BITS-1:0];
    end
    if (ctrl.search || ctrl.shift) begin
      pend_idx_r <= idx_r;
    end
    if (ctrl.search && match_now) begin
      vout_r <= rd_val;
    end
    if (ctrl.finish) begin
      found_r       <= hit_r;
      value_out_r   <= value_out_nxt;
      entry_count_r <= count_ext[kts_pkg::COUNT_W-1:0];
      is_empty_r    <= (count_nxt == '0);
      is_full_r     <= (count_nxt == CW'(DEPTH));
      status_r      <= status_nxt;
    end
  end

  assign sts.match     = match_now;
  assign sts.scan_done = !pend_r && !issue;
  assign sts.is_delete = (cmd_r == kts_pkg::CMD_DELETE);
  assign sts.hit       = hit_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_value_out   = value_out_r;
  assign out_entry_count = entry_count_r;
  assign out_is_empty    = is_empty_r;
  assign out_is_full     = is_full_r;
  assign out_status      = status_r;

endmodule

// File: sv/kts_ctrl.sv
// Controller state machine that sequences search, shift and result of each transaction.
module kts_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  kts_pkg::kts_dp_sts_t  sts,
  output kts_pkg::kts_ctrl_t    ctrl,
  output kts_pkg::kts_state_t   state
);

  kts_pkg::kts_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    case (state_r)
      kts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = kts_pkg::S_SEARCH;
        end
      end
      kts_pkg::S_SEARCH: begin
        ctrl.search = 1'b1;
        if (sts.match) begin
          state_nxt = sts.is_delete ? kts_pkg::S_SHIFT : kts_pkg::S_FINISH;
        end else if (sts.scan_done) begin
          state_nxt = kts_pkg::S_FINISH;
        end
      end
      kts_pkg::S_SHIFT: begin
        ctrl.shift = 1'b1;
        if (sts.scan_done) begin
          state_nxt = kts_pkg::S_FINISH;
        end
      end
      kts_pkg::S_FINISH: begin
        if (sts.out_free) begin
          ctrl.finish = 1'b1;
          state_nxt   = kts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kts_pkg::S_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule
